>>> src/bps_pkg.sv
// ----------------------------------------------------------------------------
// bps_pkg
// Shared widths, register indexes, reset values and the register bundle type
// of the Blinn-Phong shader core.
// ----------------------------------------------------------------------------
package bps_pkg;

  // default fraction bits of the fixed-point format
  localparam int FRAC_BITS_DEF = 14;

  // field widths
  localparam int VEC_W      = 16;
  localparam int COL_W      = 15;
  localparam int SHIN_W     = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // squared half-vector length and its root
  localparam int SQ_W  = 32;
  localparam int LEN_W = 16;

  // register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DIR_X     = 3'd0,
    REG_DIR_Y     = 3'd1,
    REG_DIR_Z     = 3'd2,
    REG_COL_R     = 3'd3,
    REG_COL_G     = 3'd4,
    REG_COL_B     = 3'd5,
    REG_SHININESS = 3'd6
  } reg_idx_t;

  // reset values
  localparam logic signed [VEC_W-1:0] RST_DIR_X = 16'sd0;
  localparam logic signed [VEC_W-1:0] RST_DIR_Y = -16'sd16384;
  localparam logic signed [VEC_W-1:0] RST_DIR_Z = 16'sd0;
  localparam logic [COL_W-1:0]        RST_COL   = 15'd16384;
  localparam logic [SHIN_W-1:0]       RST_SHIN  = 8'd16;

  // light setup as seen by the datapath
  typedef struct packed {
    logic signed [VEC_W-1:0] dir_x;
    logic signed [VEC_W-1:0] dir_y;
    logic signed [VEC_W-1:0] dir_z;
    logic [COL_W-1:0]        col_r;
    logic [COL_W-1:0]        col_g;
    logic [COL_W-1:0]        col_b;
    logic [SHIN_W-1:0]       shininess;
  } cfg_t;

endpackage

>>> src/bps_if.sv
// ----------------------------------------------------------------------------
// bps_if
// Valid/ready channels of the shader core: voxel requests, shaded results
// and register writes.
// ----------------------------------------------------------------------------
interface bps_in_if import bps_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [VEC_W-1:0] normal_x;
  logic signed [VEC_W-1:0] normal_y;
  logic signed [VEC_W-1:0] normal_z;
  logic [COL_W-1:0]        color_r;
  logic [COL_W-1:0]        color_g;
  logic [COL_W-1:0]        color_b;
  logic signed [VEC_W-1:0] view_x;
  logic signed [VEC_W-1:0] view_y;
  logic signed [VEC_W-1:0] view_z;

  modport source (output valid, normal_x, normal_y, normal_z, color_r, color_g, color_b,
                  view_x, view_y, view_z, input ready);
  modport sink (input valid, normal_x, normal_y, normal_z, color_r, color_g, color_b,
                view_x, view_y, view_z, output ready);
endinterface

interface bps_out_if import bps_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [COL_W-1:0] shade_red;
  logic [COL_W-1:0] shade_green;
  logic [COL_W-1:0] shade_blue;

  modport source (output valid, shade_red, shade_green, shade_blue, input ready);
  modport sink (input valid, shade_red, shade_green, shade_blue, output ready);
endinterface

interface bps_cfg_if import bps_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

>>> src/bps_cfg_regs.sv
// ----------------------------------------------------------------------------
// bps_cfg_regs
// Light direction, light color and shininess registers with their write port.
// ----------------------------------------------------------------------------
module bps_cfg_regs import bps_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  bps_cfg_if.sink   cfg,
  output cfg_t      regs
);

  // writes are always taken
  assign cfg.ready = 1'b1;

  // register file
  always_ff @(posedge clk) begin
    if (rst) begin
      regs.dir_x     <= RST_DIR_X;
      regs.dir_y     <= RST_DIR_Y;
      regs.dir_z     <= RST_DIR_Z;
      regs.col_r     <= RST_COL;
      regs.col_g     <= RST_COL;
      regs.col_b     <= RST_COL;
      regs.shininess <= RST_SHIN;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_DIR_X:     regs.dir_x     <= cfg.data;
        REG_DIR_Y:     regs.dir_y     <= cfg.data;
        REG_DIR_Z:     regs.dir_z     <= cfg.data;
        REG_COL_R:     regs.col_r     <= cfg.data[COL_W-1:0];
        REG_COL_G:     regs.col_g     <= cfg.data[COL_W-1:0];
        REG_COL_B:     regs.col_b     <= cfg.data[COL_W-1:0];
        REG_SHININESS: regs.shininess <= cfg.data[SHIN_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

>>> src/bps_isqrt.sv
// ----------------------------------------------------------------------------
// bps_isqrt
// Pipelined integer square root, one result bit per stage, with sideband
// data carried alongside.
// ----------------------------------------------------------------------------
module bps_isqrt import bps_pkg::*; #(
  parameter type side_t = logic
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             in_vld,
  input  logic [SQ_W-1:0]  sq,
  input  side_t            in_side,
  output logic             out_vld,
  output logic [LEN_W-1:0] len,
  output side_t            out_side
);

  localparam int STEPS = SQ_W / 2;

  logic            vld_q  [STEPS];
  logic [SQ_W-1:0] rem_q  [STEPS];
  logic [SQ_W-1:0] res_q  [STEPS];
  side_t           side_q [STEPS];

  for (genvar i = 0; i < STEPS; i++) begin : g_step
    localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (SQ_W - 2 - 2 * i);
    logic            cur_vld;
    logic [SQ_W-1:0] cur_rem;
    logic [SQ_W-1:0] cur_res;
    logic [SQ_W-1:0] trial;
    side_t           cur_side;

    if (i == 0) begin : g_first
      assign cur_vld  = in_vld;
      assign cur_rem  = sq;
      assign cur_res  = '0;
      assign cur_side = in_side;
    end else begin : g_next
      assign cur_vld  = vld_q[i-1];
      assign cur_rem  = rem_q[i-1];
      assign cur_res  = res_q[i-1];
      assign cur_side = side_q[i-1];
    end

    assign trial = cur_res + BIT;

    // one restoring root step
    always_ff @(posedge clk) begin
      if (rst) begin
        vld_q[i] <= 1'b0;
      end else if (en) begin
        vld_q[i] <= cur_vld;
      end
      if (en) begin
        if (cur_rem >= trial) begin
          rem_q[i] <= cur_rem - trial;
          res_q[i] <= (cur_res >> 1) + BIT;
        end else begin
          rem_q[i] <= cur_rem;
          res_q[i] <= cur_res >> 1;
        end
        side_q[i] <= cur_side;
      end
    end
  end

  assign out_vld  = vld_q[STEPS-1];
  assign len      = res_q[STEPS-1][LEN_W-1:0];
  assign out_side = side_q[STEPS-1];

endmodule

>>> src/bps_div.sv
// ----------------------------------------------------------------------------
// bps_div
// Three-lane pipelined divider normalizing the half vector: each lane forms
// (|h| << F) / len one quotient bit per stage, restores the sign, 0 if len=0.
// ----------------------------------------------------------------------------
module bps_div import bps_pkg::*; #(
  parameter int  FRAC_BITS = FRAC_BITS_DEF,
  parameter type side_t    = logic
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          in_vld,
  input  logic [2:0][COL_W-1:0]         mag,
  input  logic [2:0]                    neg,
  input  logic [LEN_W-1:0]              len,
  input  side_t                         in_side,
  output logic                          out_vld,
  output logic [2:0][FRAC_BITS+1:0]     hn,
  output side_t                         out_side
);

  localparam int F     = FRAC_BITS;
  localparam int STEPS = F + 1;
  localparam int QW    = F + 1;
  localparam int HNW   = F + 2;
  localparam int RW    = LEN_W + F;

  logic             vld_q  [STEPS];
  logic [RW-1:0]    rem_q  [STEPS][3];
  logic [QW-1:0]    q_q    [STEPS][3];
  logic [2:0]       neg_q  [STEPS];
  logic [LEN_W-1:0] len_q  [STEPS];
  side_t            side_q [STEPS];

  for (genvar j = 0; j < STEPS; j++) begin : g_step
    localparam int K = F - j;
    logic             cur_vld;
    logic [2:0]       cur_neg;
    logic [LEN_W-1:0] cur_len;
    side_t            cur_side;
    logic [RW-1:0]    trial;

    if (j == 0) begin : g_first
      assign cur_vld  = in_vld;
      assign cur_neg  = neg;
      assign cur_len  = len;
      assign cur_side = in_side;
    end else begin : g_next
      assign cur_vld  = vld_q[j-1];
      assign cur_neg  = neg_q[j-1];
      assign cur_len  = len_q[j-1];
      assign cur_side = side_q[j-1];
    end

    assign trial = RW'(cur_len) << K;

    // control and sideband
    always_ff @(posedge clk) begin
      if (rst) begin
        vld_q[j] <= 1'b0;
      end else if (en) begin
        vld_q[j] <= cur_vld;
      end
      if (en) begin
        neg_q[j]  <= cur_neg;
        len_q[j]  <= cur_len;
        side_q[j] <= cur_side;
      end
    end

    for (genvar l = 0; l < 3; l++) begin : g_lane
      logic [RW-1:0] cur_rem;
      logic [QW-1:0] cur_q;

      if (j == 0) begin : g_first
        assign cur_rem = RW'({mag[l], {F{1'b0}}});
        assign cur_q   = '0;
      end else begin : g_next
        assign cur_rem = rem_q[j-1][l];
        assign cur_q   = q_q[j-1][l];
      end

      // one restoring division step
      always_ff @(posedge clk) begin
        if (en) begin
          if (cur_rem >= trial) begin
            rem_q[j][l] <= cur_rem - trial;
            q_q[j][l]   <= cur_q | (QW'(1) << K);
          end else begin
            rem_q[j][l] <= cur_rem;
            q_q[j][l]   <= cur_q;
          end
        end
      end
    end
  end

  // sign and zero-length handling
  always_comb begin
    for (int l = 0; l < 3; l++) begin
      if (len_q[STEPS-1] == '0) begin
        hn[l] = '0;
      end else if (neg_q[STEPS-1][l]) begin
        hn[l] = HNW'(0) - HNW'(q_q[STEPS-1][l]);
      end else begin
        hn[l] = HNW'(q_q[STEPS-1][l]);
      end
    end
  end

  assign out_vld  = vld_q[STEPS-1];
  assign out_side = side_q[STEPS-1];

endmodule

>>> src/bps_pow.sv
// ----------------------------------------------------------------------------
// bps_pow
// Pipelined square-and-multiply power, one exponent bit per stage, lsb first.
// ----------------------------------------------------------------------------
module bps_pow import bps_pkg::*; #(
  parameter int  FRAC_BITS = FRAC_BITS_DEF,
  parameter type side_t    = logic
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 in_vld,
  input  logic [FRAC_BITS:0]   base,
  input  logic [SHIN_W-1:0]    expo,
  input  side_t                in_side,
  output logic                 out_vld,
  output logic [FRAC_BITS:0]   p,
  output side_t                out_side
);

  localparam int F     = FRAC_BITS;
  localparam int OW    = F + 1;
  localparam int PW    = 2 * OW;
  localparam int STEPS = SHIN_W;
  localparam logic [OW-1:0] ONE = {1'b1, {F{1'b0}}};

  logic          vld_q  [STEPS];
  logic [OW-1:0] r_q    [STEPS];
  logic [OW-1:0] b_q    [STEPS];
  side_t         side_q [STEPS];

  for (genvar i = 0; i < STEPS; i++) begin : g_step
    logic          cur_vld;
    logic [OW-1:0] cur_r;
    logic [OW-1:0] cur_b;
    side_t         cur_side;
    logic [PW-1:0] prod_rb;
    logic [PW-1:0] prod_bb;

    if (i == 0) begin : g_first
      assign cur_vld  = in_vld;
      assign cur_r    = ONE;
      assign cur_b    = base;
      assign cur_side = in_side;
    end else begin : g_next
      assign cur_vld  = vld_q[i-1];
      assign cur_r    = r_q[i-1];
      assign cur_b    = b_q[i-1];
      assign cur_side = side_q[i-1];
    end

    assign prod_rb = PW'(cur_r) * PW'(cur_b);
    assign prod_bb = PW'(cur_b) * PW'(cur_b);

    // multiply in when the exponent bit is set, square the base
    always_ff @(posedge clk) begin
      if (rst) begin
        vld_q[i] <= 1'b0;
      end else if (en) begin
        vld_q[i] <= cur_vld;
      end
      if (en) begin
        r_q[i]    <= expo[i] ? OW'(prod_rb >> F) : cur_r;
        b_q[i]    <= OW'(prod_bb >> F);
        side_q[i] <= cur_side;
      end
    end
  end

  assign out_vld  = vld_q[STEPS-1];
  assign p        = r_q[STEPS-1];
  assign out_side = side_q[STEPS-1];

endmodule

>>> src/blinn_phong_shader_core.sv
// ----------------------------------------------------------------------------
// blinn_phong_shader_core
// Blinn-Phong voxel shading: diffuse from the light direction, specular from
// the normalized half vector raised to the shininess, clamped per channel.
//
// Channels: voxel_in takes one voxel request (normal, base color, view
// vector); shade_out returns one shaded color per request, in order; cfg
// writes the light registers (direction, color, shininess) and is always
// ready. Registers should only change while no request is in flight.
// Throughput: one request per clock while shade_out is not stalled.
// Pipeline: the square root (16 stages, one root bit each), the half-vector
// divider (FRAC_BITS + 1 stages, one quotient bit each) and the power unit
// (8 stages, one exponent bit each) plus 8 arithmetic stages.
// Stall: the whole pipeline advances together; while a result sits unread
// in the output register, voxel_in.ready is low and every stage holds.
// Reset: clears all valid bits and loads the register reset values.
// ----------------------------------------------------------------------------
module blinn_phong_shader_core import bps_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  bps_in_if.sink     voxel_in,
  bps_out_if.source  shade_out,
  bps_cfg_if.sink    cfg
);

  localparam int F    = FRAC_BITS;
  localparam int OW   = F + 1;
  localparam int HNW  = F + 2;
  localparam int P2W  = HNW + VEC_W;
  localparam int S2W  = P2W + 2;
  localparam int CLW  = 2 * COL_W;
  localparam int CSW  = CLW - F;
  localparam int DPW  = CSW + OW;
  localparam int SPW  = COL_W + OW;
  localparam int SUMW = 32;
  localparam logic [OW-1:0] ONE = {1'b1, {F{1'b0}}};

  typedef struct packed {
    logic [OW-1:0]           d;
    logic [2:0][VEC_W-1:0]   h;
    logic [2:0][VEC_W-1:0]   n;
    logic [2:0][COL_W-1:0]   col;
  } sq_side_t;

  typedef struct packed {
    logic [OW-1:0]           d;
    logic [2:0][VEC_W-1:0]   n;
    logic [2:0][COL_W-1:0]   col;
  } div_side_t;

  typedef struct packed {
    logic [OW-1:0]           d;
    logic [2:0][COL_W-1:0]   col;
  } pow_side_t;

  cfg_t regs;

  bps_cfg_regs u_cfg (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  // global advance: output register empty or being taken
  logic en;
  logic o_vld;
  assign en             = !o_vld || shade_out.ready;
  assign voxel_in.ready = en;

  logic signed [VEC_W-1:0] ldir  [3];
  logic [COL_W-1:0]        lcol  [3];
  logic signed [VEC_W-1:0] in_n  [3];
  logic signed [VEC_W-1:0] in_v  [3];
  logic [COL_W-1:0]        in_c  [3];

  assign ldir = '{regs.dir_x, regs.dir_y, regs.dir_z};
  assign lcol = '{regs.col_r, regs.col_g, regs.col_b};
  assign in_n = '{voxel_in.normal_x, voxel_in.normal_y, voxel_in.normal_z};
  assign in_v = '{voxel_in.view_x, voxel_in.view_y, voxel_in.view_z};
  assign in_c = '{voxel_in.color_r, voxel_in.color_g, voxel_in.color_b};

  // stage 1: n.l products and half vector
  logic                    s1_vld;
  logic signed [31:0]      s1_pn  [3];
  logic signed [VEC_W-1:0] s1_h   [3];
  logic signed [VEC_W-1:0] s1_n   [3];
  logic [COL_W-1:0]        s1_col [3];
  logic signed [VEC_W:0]   dv     [3];
  logic signed [VEC_W:0]   dv_r   [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dv[i]   = (VEC_W+1)'(in_v[i]) - (VEC_W+1)'(ldir[i]);
      dv_r[i] = dv[i] + (VEC_W+1)'(dv[i][VEC_W]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
    end else if (en) begin
      s1_vld <= voxel_in.valid;
    end
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        s1_pn[i]  <= 32'(in_n[i]) * 32'(ldir[i]);
        s1_h[i]   <= VEC_W'(dv_r[i] >>> 1);
        s1_n[i]   <= in_n[i];
        s1_col[i] <= in_c[i];
      end
    end
  end

  // stage 2: clamped diffuse term, half-vector squares
  logic                    s2_vld;
  logic [OW-1:0]           s2_d;
  logic [30:0]             s2_hsq [3];
  logic signed [VEC_W-1:0] s2_h   [3];
  logic signed [VEC_W-1:0] s2_n   [3];
  logic [COL_W-1:0]        s2_col [3];
  logic signed [34:0]      ndot;
  logic signed [34:0]      ndot_sh;
  logic [OW-1:0]           d_sat;
  logic [31:0]             hsq    [3];

  always_comb begin
    ndot    = 35'sd0 - (35'(s1_pn[0]) + 35'(s1_pn[1]) + 35'(s1_pn[2]));
    ndot_sh = ndot >>> F;
    if (ndot <= 35'sd0) begin
      d_sat = '0;
    end else if (ndot_sh > 35'(ONE)) begin
      d_sat = ONE;
    end else begin
      d_sat = OW'(ndot_sh);
    end
    for (int i = 0; i < 3; i++) begin
      hsq[i] = 32'(s1_h[i]) * 32'(s1_h[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_vld <= 1'b0;
    end else if (en) begin
      s2_vld <= s1_vld;
    end
    if (en) begin
      s2_d <= d_sat;
      for (int i = 0; i < 3; i++) begin
        s2_hsq[i] <= hsq[i][30:0];
        s2_h[i]   <= s1_h[i];
        s2_n[i]   <= s1_n[i];
        s2_col[i] <= s1_col[i];
      end
    end
  end

  // stage 3: squared length
  logic            s3_vld;
  logic [SQ_W-1:0] s3_sq;
  sq_side_t        s3_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_vld <= 1'b0;
    end else if (en) begin
      s3_vld <= s2_vld;
    end
    if (en) begin
      s3_sq     <= SQ_W'(s2_hsq[0]) + SQ_W'(s2_hsq[1]) + SQ_W'(s2_hsq[2]);
      s3_side.d <= s2_d;
      for (int i = 0; i < 3; i++) begin
        s3_side.h[i]   <= s2_h[i];
        s3_side.n[i]   <= s2_n[i];
        s3_side.col[i] <= s2_col[i];
      end
    end
  end

  // half-vector length
  logic             sq_vld;
  logic [LEN_W-1:0] sq_len;
  sq_side_t         sq_side;

  bps_isqrt #(.side_t(sq_side_t)) u_isqrt (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_vld   (s3_vld),
    .sq       (s3_sq),
    .in_side  (s3_side),
    .out_vld  (sq_vld),
    .len      (sq_len),
    .out_side (sq_side)
  );

  // normalize the half vector
  logic [2:0][COL_W-1:0] dv_mag;
  logic [2:0]            dv_neg;
  div_side_t             dv_side_in;
  logic                  dv_vld;
  logic [2:0][HNW-1:0]   dv_hn;
  div_side_t             dv_side;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dv_neg[i] = sq_side.h[i][VEC_W-1];
      dv_mag[i] = dv_neg[i] ? COL_W'(VEC_W'(0) - sq_side.h[i]) : sq_side.h[i][COL_W-1:0];
    end
    dv_side_in.d   = sq_side.d;
    dv_side_in.n   = sq_side.n;
    dv_side_in.col = sq_side.col;
  end

  bps_div #(.FRAC_BITS(F), .side_t(div_side_t)) u_div (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_vld   (sq_vld),
    .mag      (dv_mag),
    .neg      (dv_neg),
    .len      (sq_len),
    .in_side  (dv_side_in),
    .out_vld  (dv_vld),
    .hn       (dv_hn),
    .out_side (dv_side)
  );

  // stage 4: h.n products
  logic                  s4_vld;
  logic signed [P2W-1:0] s4_p2 [3];
  pow_side_t             s4_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_vld <= 1'b0;
    end else if (en) begin
      s4_vld <= dv_vld;
    end
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        s4_p2[i] <= P2W'($signed(dv_hn[i])) * P2W'($signed(dv_side.n[i]));
      end
      s4_side.d   <= dv_side.d;
      s4_side.col <= dv_side.col;
    end
  end

  // stage 5: clamped specular base
  logic                  s5_vld;
  logic [OW-1:0]         s5_s;
  pow_side_t             s5_side;
  logic signed [S2W-1:0] hdot;
  logic signed [S2W-1:0] hdot_sh;
  logic [OW-1:0]         s_sat;

  always_comb begin
    hdot    = S2W'(s4_p2[0]) + S2W'(s4_p2[1]) + S2W'(s4_p2[2]);
    hdot_sh = hdot >>> F;
    if (hdot <= $signed(S2W'(0))) begin
      s_sat = '0;
    end else if (hdot_sh > S2W'(ONE)) begin
      s_sat = ONE;
    end else begin
      s_sat = OW'(hdot_sh);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s5_vld <= 1'b0;
    end else if (en) begin
      s5_vld <= s4_vld;
    end
    if (en) begin
      s5_s    <= s_sat;
      s5_side <= s4_side;
    end
  end

  // specular power
  logic          pw_vld;
  logic [OW-1:0] pw_p;
  pow_side_t     pw_side;

  bps_pow #(.FRAC_BITS(F), .side_t(pow_side_t)) u_pow (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_vld   (s5_vld),
    .base     (s5_s),
    .expo     (regs.shininess),
    .in_side  (s5_side),
    .out_vld  (pw_vld),
    .p        (pw_p),
    .out_side (pw_side)
  );

  // stage 6: color times light, specular times light
  logic             s6_vld;
  logic [CLW-1:0]   s6_cl [3];
  logic [COL_W:0]   s6_sp [3];
  logic [OW-1:0]    s6_d;
  logic [SPW-1:0]   sp_prod [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sp_prod[i] = SPW'(lcol[i]) * SPW'(pw_p);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s6_vld <= 1'b0;
    end else if (en) begin
      s6_vld <= pw_vld;
    end
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        s6_cl[i] <= CLW'(pw_side.col[i]) * CLW'(lcol[i]);
        s6_sp[i] <= (COL_W+1)'(sp_prod[i] >> F);
      end
      s6_d <= pw_side.d;
    end
  end

  // stage 7: diffuse scaled by the clamped n.l
  logic           s7_vld;
  logic [DPW-1:0] s7_dp [3];
  logic [COL_W:0] s7_sp [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      s7_vld <= 1'b0;
    end else if (en) begin
      s7_vld <= s6_vld;
    end
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        s7_dp[i] <= DPW'(s6_cl[i][CLW-1:F]) * DPW'(s6_d);
        s7_sp[i] <= s6_sp[i];
      end
    end
  end

  // output register: sum, clamp to one, keep the low bits
  logic [SUMW-1:0]  tot [3];
  logic [COL_W-1:0] o_shade [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      tot[i] = SUMW'(s7_dp[i] >> F) + SUMW'(s7_sp[i]);
      if (tot[i] > SUMW'(ONE)) begin
        tot[i] = SUMW'(ONE);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      o_vld <= 1'b0;
    end else if (en) begin
      o_vld <= s7_vld;
    end
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        o_shade[i] <= tot[i][COL_W-1:0];
      end
    end
  end

  assign shade_out.valid       = o_vld;
  assign shade_out.shade_red   = o_shade[0];
  assign shade_out.shade_green = o_shade[1];
  assign shade_out.shade_blue  = o_shade[2];

endmodule

>>> src/bps_checker.sv
// ----------------------------------------------------------------------------
// bps_checker
// Port-level checks of the shader core: result hold under stall, reset
// behavior, back-pressure and the always-ready register port.
// ----------------------------------------------------------------------------
module bps_checker import bps_pkg::*; (
  input logic             clk,
  input logic             rst,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input logic [COL_W-1:0] shade_red,
  input logic [COL_W-1:0] shade_green,
  input logic [COL_W-1:0] shade_blue,
  input logic             cfg_valid,
  input logic             cfg_ready
);

  // a stalled result stays
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // a stalled result keeps its value
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(shade_red) && $stable(shade_green)
                                && $stable(shade_blue))
    else $error("result changed while stalled");

  // nothing comes out right after reset
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result valid right after reset");

  // an empty output never blocks new requests
  a_no_block: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input blocked with empty output");

  // register writes are never refused
  a_cfg_ready: assert property (@(posedge clk) disable iff (rst)
    cfg_valid |-> cfg_ready)
    else $error("register write refused");

endmodule

bind blinn_phong_shader_core bps_checker u_bps_checker (
  .clk         (clk),
  .rst         (rst),
  .in_ready    (voxel_in.ready),
  .out_valid   (shade_out.valid),
  .out_ready   (shade_out.ready),
  .shade_red   (shade_out.shade_red),
  .shade_green (shade_out.shade_green),
  .shade_blue  (shade_out.shade_blue),
  .cfg_valid   (cfg.valid),
  .cfg_ready   (cfg.ready)
);

>>> bench/blinn_phong_shader_core_tb.sv
// ----------------------------------------------------------------------------
// blinn_phong_shader_core_tb
// Drives voxel requests with random idling on both sides, writes the light
// registers between phases and checks every shaded result against a
// bit-exact fixed-point predictor, queued in a small scoreboard class.
// ----------------------------------------------------------------------------
module blinn_phong_shader_core_tb;
  import bps_pkg::*;

  localparam int F       = FRAC_BITS_DEF;
  localparam longint ONE = 64'sd1 << F;
  localparam int LAT     = 33 + F;
  localparam longint LIMIT = 2000000;

  typedef struct {
    logic signed [VEC_W-1:0] n [3];
    logic [COL_W-1:0]        c [3];
    logic signed [VEC_W-1:0] v [3];
  } voxel_t;

  typedef struct {
    logic [COL_W-1:0] ch [3];
  } shade_t;

  // light setup as seen by the predictor
  typedef struct {
    longint dir [3];
    longint col [3];
    int     shin;
  } light_t;

  // clamp01 of a raw dot product
  function automatic longint clamp_dot(longint dot);
    longint t;
    if (dot <= 0) return 0;
    t = dot >>> F;
    return (t > ONE) ? ONE : t;
  endfunction

  function automatic longint div_trunc(longint a, longint b);
    return (a < 0) ? -((-a) / b) : a / b;
  endfunction

  function automatic longint int_sqrt(longint x);
    longint r, b;
    r = 0;
    b = 64'sd1 << 62;
    while (b > x) b = b >>> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >>> 1) + b;
      end else begin
        r = r >>> 1;
      end
      b = b >>> 2;
    end
    return r;
  endfunction

  // lsb-first square-and-multiply over 8 bits
  function automatic longint pow_fix(longint b, int e);
    longint r;
    r = ONE;
    for (int i = 0; i < 8; i++) begin
      if (e[i]) r = (r * b) >>> F;
      b = (b * b) >>> F;
    end
    return r;
  endfunction

  function automatic shade_t shade_voxel(voxel_t x, light_t l);
    shade_t o;
    longint dot, d, s, p, sq, len, diff, spec, sum;
    longint h [3];
    longint hn [3];
    dot = 0;
    for (int i = 0; i < 3; i++) dot += longint'(x.n[i]) * l.dir[i];
    d = clamp_dot(-dot);
    sq = 0;
    for (int i = 0; i < 3; i++) begin
      h[i] = div_trunc(longint'(x.v[i]) - l.dir[i], 2);
      sq += h[i] * h[i];
    end
    len = int_sqrt(sq);
    for (int i = 0; i < 3; i++) hn[i] = (len == 0) ? 0 : div_trunc(h[i] * ONE, len);
    dot = 0;
    for (int i = 0; i < 3; i++) dot += hn[i] * longint'(x.n[i]);
    s = clamp_dot(dot);
    p = pow_fix(s, l.shin);
    for (int i = 0; i < 3; i++) begin
      diff = (((longint'(x.c[i]) * l.col[i]) >>> F) * d) >>> F;
      spec = (l.col[i] * p) >>> F;
      sum = diff + spec;
      if (sum > ONE) sum = ONE;
      o.ch[i] = sum[COL_W-1:0];
    end
    return o;
  endfunction

  class shade_scoreboard;
    shade_t pending[$];
    light_t light;
    int     errors;

    function void note_voxel(voxel_t x);
      pending.push_back(shade_voxel(x, light));
    endfunction

    function void check_shade(shade_t got);
      shade_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %0d %0d %0d", $time,
                 got.ch[0], got.ch[1], got.ch[2]);
        errors++;
        return;
      end
      want = pending.pop_front();
      for (int i = 0; i < 3; i++)
        if (got.ch[i] !== want.ch[i]) begin
          $display("%0t: channel %0d expected %0d actual %0d", $time, i,
                   want.ch[i], got.ch[i]);
          errors++;
        end
    endfunction
  endclass

  logic clk;
  logic rst;
  bps_in_if  voxel_in ();
  bps_out_if shade_out ();
  bps_cfg_if cfg ();

  blinn_phong_shader_core u_top (
    .clk       (clk),
    .rst       (rst),
    .voxel_in  (voxel_in.sink),
    .shade_out (shade_out.source),
    .cfg       (cfg.sink)
  );

  shade_scoreboard sb;
  bit     no_idle;
  longint cycles = 0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // cycle limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // result side: sample at rising edge, stall in bursts
  always @(posedge clk) begin
    shade_t got;
    if (!rst && shade_out.valid && shade_out.ready) begin
      got.ch[0] = shade_out.shade_red;
      got.ch[1] = shade_out.shade_green;
      got.ch[2] = shade_out.shade_blue;
      sb.check_shade(got);
    end
  end

  initial begin
    int k;
    shade_out.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (!no_idle && $urandom_range(0, 5) == 0) begin
        shade_out.ready = 1'b0;
        k = $urandom_range(1, 9);
        repeat (k - 1) @(negedge clk);
      end else begin
        shade_out.ready = 1'b1;
      end
    end
  end

  task automatic write_reg(reg_idx_t idx, logic [CFG_DATA_W-1:0] val);
    cfg.valid = 1'b1;
    cfg.index = idx;
    cfg.data  = val;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    @(negedge clk);
    cfg.valid = 1'b0;
    case (idx)
      REG_DIR_X, REG_DIR_Y, REG_DIR_Z: sb.light.dir[idx] = longint'($signed(val));
      REG_COL_R, REG_COL_G, REG_COL_B:
        sb.light.col[idx - REG_COL_R] = longint'(val[COL_W-1:0]);
      REG_SHININESS: sb.light.shin = int'(val[SHIN_W-1:0]);
      default: ;
    endcase
  endtask

  // request with optional idle burst first
  task automatic send_voxel(voxel_t x);
    if (!no_idle && $urandom_range(0, 5) == 0) begin
      voxel_in.valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(negedge clk);
    end
    voxel_in.valid    <= 1'b1;
    voxel_in.normal_x <= x.n[0];
    voxel_in.normal_y <= x.n[1];
    voxel_in.normal_z <= x.n[2];
    voxel_in.color_r  <= x.c[0];
    voxel_in.color_g  <= x.c[1];
    voxel_in.color_b  <= x.c[2];
    voxel_in.view_x   <= x.v[0];
    voxel_in.view_y   <= x.v[1];
    voxel_in.view_z   <= x.v[2];
    @(posedge clk);
    while (!voxel_in.ready) @(posedge clk);
    sb.note_voxel(x);
    @(negedge clk);
  endtask

  task automatic drain();
    voxel_in.valid <= 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (LAT + 4) @(negedge clk);
  endtask

  function automatic logic signed [VEC_W-1:0] rand_comp();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 16'sh8000 + $urandom_range(0, 3);
    if (r == 1) return 16'sh7fff - $urandom_range(0, 3);
    if (r == 2) return $urandom_range(0, 1) ? 16'sd16384 : -16'sd16384;
    return $signed(16'($urandom_range(0, 32768))) - 16'sd16384;
  endfunction

  // mostly unit-ish vectors, sometimes raw bit patterns
  function automatic voxel_t rand_voxel();
    voxel_t x;
    for (int i = 0; i < 3; i++) begin
      x.n[i] = rand_comp();
      x.v[i] = rand_comp();
      x.c[i] = ($urandom_range(0, 7) == 0) ? 15'($urandom) : 15'($urandom_range(0, 16384));
    end
    if ($urandom_range(0, 2) == 0) begin
      x.n[$urandom_range(0, 2)] = 16'sd0;
      x.v[$urandom_range(0, 2)] = 16'sd0;
    end
    return x;
  endfunction

  function automatic voxel_t uni_voxel(int nx, int ny, int nz, int vx, int vy, int vz,
                                       int cc);
    voxel_t x;
    x.n[0] = VEC_W'(nx); x.n[1] = VEC_W'(ny); x.n[2] = VEC_W'(nz);
    x.v[0] = VEC_W'(vx); x.v[1] = VEC_W'(vy); x.v[2] = VEC_W'(vz);
    for (int i = 0; i < 3; i++) x.c[i] = COL_W'(cc);
    return x;
  endfunction

  task automatic rand_light(bit extreme);
    reg_idx_t idx;
    for (int i = 0; i < 7; i++) begin
      idx = reg_idx_t'(i);
      if (i < 3)
        write_reg(idx, extreme ? (($urandom_range(0, 1)) ? 16'h4000 : 16'hc000)
                               : 16'(rand_comp()));
      else if (i < 6)
        write_reg(idx, extreme ? ($urandom_range(0, 1) ? 16'd16384 : 16'd0)
                               : 16'($urandom_range(0, 32767)));
      else
        write_reg(idx, extreme ? ($urandom_range(0, 1) ? 16'd255 : 16'd0)
                               : 16'($urandom_range(0, 255)));
    end
  endtask

  initial begin
    voxel_t x;
    sb = new();
    sb.light.dir[0] = longint'(RST_DIR_X);
    sb.light.dir[1] = longint'(RST_DIR_Y);
    sb.light.dir[2] = longint'(RST_DIR_Z);
    for (int i = 0; i < 3; i++) sb.light.col[i] = longint'(RST_COL);
    sb.light.shin = int'(RST_SHIN);
    no_idle = 1'b0;
    rst = 1'b1;
    voxel_in.valid = 1'b0;
    voxel_in.normal_x = '0; voxel_in.normal_y = '0; voxel_in.normal_z = '0;
    voxel_in.color_r = '0; voxel_in.color_g = '0; voxel_in.color_b = '0;
    voxel_in.view_x = '0; voxel_in.view_y = '0; voxel_in.view_z = '0;
    cfg.valid = 1'b0;
    cfg.index = '0;
    cfg.data = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: reset light, facing, grazing, zero half vector, extremes
    send_voxel(uni_voxel(0, 16384, 0, 0, 16384, 0, 16384));
    send_voxel(uni_voxel(0, -16384, 0, 0, 16384, 0, 16384));
    send_voxel(uni_voxel(16384, 0, 0, 0, -16384, 0, 8192));
    send_voxel(uni_voxel(0, 16384, 0, 0, -16384, 0, 16384));
    send_voxel(uni_voxel(-32768, -32768, -32768, 32767, 32767, 32767, 32767));
    send_voxel(uni_voxel(32767, 32767, 32767, -32768, -32768, -32768, 0));
    send_voxel(uni_voxel(0, 0, 0, 0, 0, 0, 0));
    drain();
    // zero to the zero, zero light color, large light color
    write_reg(REG_SHININESS, 16'd0);
    write_reg(REG_COL_R, 16'd0);
    write_reg(REG_COL_G, 16'd32767);
    write_reg(REG_COL_B, 16'h8000);
    write_reg(REG_DIR_X, 16'h7fff);
    write_reg(REG_DIR_Y, 16'h8000);
    write_reg(REG_DIR_Z, 16'd0);
    send_voxel(uni_voxel(0, 16384, 0, 0, -16384, 0, 16384));
    send_voxel(uni_voxel(0, 0, 0, 32767, -32768, 0, 32767));
    send_voxel(uni_voxel(-16384, 0, 0, 0, 0, 16384, 4096));
    drain();
    write_reg(REG_SHININESS, 16'd255);
    write_reg(REG_DIR_X, 16'd0);
    write_reg(REG_DIR_Y, 16'd0);
    write_reg(REG_DIR_Z, 16'hc000);
    send_voxel(uni_voxel(0, 0, 16384, 0, 0, 16384, 16384));
    send_voxel(uni_voxel(0, 0, 16384, 0, 0, 16383, 16384));
    send_voxel(uni_voxel(0, 0, -16384, 0, 0, -16384, 100));
    drain();

    // random phases, each under a new light setup
    for (int ph = 0; ph < 10; ph++) begin
      rand_light(ph % 3 == 0);
      if (ph == 9) no_idle = 1'b1;
      repeat (200) begin
        x = rand_voxel();
        send_voxel(x);
      end
      drain();
    end

    if (sb.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
